@@ rtl/core/bzl_pkg.sv @@
// ----------------------------------------------------------------------------
// bzl_pkg
// Shared types, constants and helpers for the Bezier link hit test.
// ----------------------------------------------------------------------------
package bzl_pkg;

  // Curve sampling
  localparam int SEGMENTS = 64;
  localparam int SEG_LOG2 = 6;
  localparam int SEG_W    = SEG_LOG2 + 1;
  localparam int RND_SH   = 3 * SEG_LOG2;

  // Datapath widths
  localparam int COORD_W = 18;
  localparam int DIFF_W  = 19;
  localparam int MUL_W   = 20;
  localparam int PROD_W  = 2 * MUL_W;
  localparam int ACC_W   = PROD_W + 1;
  localparam int WGT_W   = RND_SH + 1;
  localparam int U_W     = 17;
  localparam int Q_W     = 16;
  localparam int DIV_W   = 39;
  localparam int DLT_W   = PROD_W - Q_W;

  // Configuration port
  localparam int ADDR_W = 3;
  localparam int DATA_W = 32;
  localparam logic REG_HIT_DIST = 1'b0;
  localparam logic REG_HANDLE   = 1'b1;
  localparam logic [7:0] HIT_DIST_RST = 8'd10;
  localparam logic [7:0] HANDLE_RST   = 8'd60;

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic signed [DIFF_W-1:0]  diff_t;
  typedef logic signed [MUL_W-1:0]   mul_op_t;
  typedef logic signed [PROD_W-1:0]  prod_t;
  typedef logic signed [ACC_W-1:0]   acc_t;
  typedef logic        [WGT_W-1:0]   wgt_t;
  typedef logic signed [DLT_W-1:0]   delta_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_SETUP, ST_BOX, ST_WEIGHT, ST_SAMPLE, ST_ROUND, ST_DIFF,
    ST_DOT, ST_DECIDE, ST_DIVIDE, ST_DIST, ST_NEXT, ST_DONE
  } state_t;

  // Bernstein sum to sample coordinate, round half up
  function automatic coord_t round_sample(acc_t a);
    acc_t t;
    t = a + (acc_t'(1) <<< (RND_SH - 1));
    return t[RND_SH+COORD_W-1:RND_SH];
  endfunction

  // Q16 value to integer, truncated toward zero
  function automatic delta_t trunc_q16(prod_t v);
    delta_t q;
    q = v[PROD_W-1:Q_W];
    if (v[PROD_W-1] && (v[Q_W-1:0] != '0)) q = q + delta_t'(1);
    return q;
  endfunction

endpackage

@@ rtl/core/bzl_if.sv @@
// ----------------------------------------------------------------------------
// bzl_req_if / bzl_rsp_if
// Request and response channels of the hit test, valid/ready handshake.
// ----------------------------------------------------------------------------
interface bzl_req_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] start_x;
  logic signed [15:0] start_y;
  logic signed [15:0] end_x;
  logic signed [15:0] end_y;
  logic signed [15:0] query_x;
  logic signed [15:0] query_y;

  modport source (output valid, start_x, start_y, end_x, end_y, query_x, query_y,
                  input ready);
  modport sink   (input valid, start_x, start_y, end_x, end_y, query_x, query_y,
                  output ready);
endinterface

interface bzl_rsp_if;
  logic valid;
  logic ready;
  logic hit;

  modport source (output valid, hit, input ready);
  modport sink   (input valid, hit, output ready);
endinterface

@@ rtl/core/bzl_mul.sv @@
// ----------------------------------------------------------------------------
// bzl_mul
// Shared signed multiplier; the sequencer registers its product.
// ----------------------------------------------------------------------------
module bzl_mul (
  input  bzl_pkg::mul_op_t a,
  input  bzl_pkg::mul_op_t b,
  output bzl_pkg::prod_t   p
);
  import bzl_pkg::*;

  // Full-width signed product
  assign p = prod_t'(a) * prod_t'(b);

endmodule

@@ rtl/core/bzl_div.sv @@
// ----------------------------------------------------------------------------
// bzl_div
// Restoring divider, one quotient bit per cycle: floor(num * 2^16 / den)
// for 0 < num < den.
// ----------------------------------------------------------------------------
module bzl_div (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic [bzl_pkg::DIV_W-1:0] num,
  input  logic [bzl_pkg::DIV_W-1:0] den,
  output logic                      busy,
  output logic                      done,
  output logic [bzl_pkg::Q_W-1:0]   quot
);
  import bzl_pkg::*;

  logic [DIV_W:0]   rem;
  logic [DIV_W-1:0] dvs;
  logic [4:0]       cnt;
  logic [DIV_W:0]   rem_sh;
  logic             fits;

  // One trial subtract per cycle
  assign rem_sh = {rem[DIV_W-1:0], 1'b0};
  assign fits   = rem_sh >= {1'b0, dvs};

  // Control
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= busy && (cnt == 5'd1);
      if (start) begin
        cnt  <= 5'(Q_W);
        busy <= 1'b1;
      end else if (busy) begin
        cnt  <= cnt - 5'd1;
        busy <= cnt != 5'd1;
      end
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    if (start) begin
      rem  <= {1'b0, num};
      dvs  <= den;
      quot <= '0;
    end else if (busy) begin
      rem  <= fits ? (rem_sh - {1'b0, dvs}) : rem_sh;
      quot <= {quot[Q_W-2:0], fits};
    end
  end

endmodule

@@ rtl/core/bezier_link_hit_test.sv @@
// ----------------------------------------------------------------------------
// bezier_link_hit_test
// Cubic Bezier link proximity test on one shared multiplier and a serial
// divider, driven by a step sequencer.
// ----------------------------------------------------------------------------
// Flow: a box reject goes straight to the response; otherwise each segment
//   runs the full sequence, skipping the divider when no divide is needed,
//   and going from the difference step to the next segment for a repeated sample.
// Requests: one at a time; per-segment time is set by the single
//   multiplier (20 products) and the serial divider.
// Reset: rst clears the sequencer and output valid, registers go to
//   hit_distance 10, handle_offset 60.
module bezier_link_hit_test (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [bzl_pkg::ADDR_W-1:0]  paddr,
  input  logic [bzl_pkg::DATA_W-1:0]  pwdata,
  output logic [bzl_pkg::DATA_W-1:0]  prdata,
  output logic                        pready,
  bzl_req_if.sink                     req,
  bzl_rsp_if.source                   rsp
);
  import bzl_pkg::*;

  state_t state, state_next;
  logic [2:0] step, step_next;

  logic [7:0] hit_distance, handle_offset;

  logic signed [15:0] sx, sy, ex, ey, qx, qy;
  coord_t cx [4];
  coord_t cy [4];
  wgt_t   w  [4];
  logic [12:0] sqi, sqr;
  logic [SEG_W-1:0] seg, rem_seg;
  coord_t lx, ly, px, py;
  diff_t  abx, aby, amx, amy;
  acc_t   acc, num;
  logic [U_W-1:0] u;
  delta_t dx;
  logic   hit_r, rsp_valid, rsp_hit;

  mul_op_t mul_a, mul_b;
  prod_t   prod;
  logic    div_start, div_busy, div_done;
  logic [Q_W-1:0] div_quot;

  // Configuration port
  assign pready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      hit_distance  <= HIT_DIST_RST;
      handle_offset <= HANDLE_RST;
    end else if (psel && penable && pwrite) begin
      case (paddr[2])
        REG_HIT_DIST: hit_distance  <= pwdata[7:0];
        REG_HANDLE:   handle_offset <= pwdata[7:0];
        default: ;
      endcase
    end
  end
  assign prdata = (paddr[2] == REG_HANDLE) ? {24'b0, handle_offset}
                                           : {24'b0, hit_distance};

  // Control points with fold-back pull-in
  coord_t c1, c2, c1_pull, c2_pull;
  logic [16:0] gap;
  logic        fold;
  always_comb begin
    c1   = coord_t'(sx) + coord_t'({1'b0, handle_offset});
    c2   = coord_t'(ex) - coord_t'({1'b0, handle_offset});
    gap  = (sy >= ey) ? 17'(18'(sy) - 18'(ey)) : 17'(18'(ey) - 18'(sy));
    fold = (c1 > coord_t'(ex)) && (gap < {9'b0, handle_offset});
    c1_pull = c1 - coord_t'({1'b0, handle_offset}) + coord_t'(gap);
    c2_pull = c2 + coord_t'({1'b0, handle_offset}) - coord_t'(gap);
  end

  // Bounding box early reject
  coord_t minx, maxx, miny, maxy;
  logic   reject;
  always_comb begin
    minx = cx[0]; maxx = cx[0]; miny = cy[0]; maxy = cy[0];
    for (int k = 1; k < 4; k++) begin
      if (cx[k] < minx) minx = cx[k];
      if (cx[k] > maxx) maxx = cx[k];
      if (cy[k] < miny) miny = cy[k];
      if (cy[k] > maxy) maxy = cy[k];
    end
    reject = (diff_t'(qx) < diff_t'(minx) - diff_t'({1'b0, hit_distance}))
          || (diff_t'(qx) > diff_t'(maxx) + diff_t'({1'b0, hit_distance}))
          || (diff_t'(qy) < diff_t'(miny) - diff_t'({1'b0, hit_distance}))
          || (diff_t'(qy) > diff_t'(maxy) + diff_t'({1'b0, hit_distance}));
  end

  // Manhattan distance test
  delta_t dy_now;
  logic [DLT_W:0] man_dist;
  logic close;
  assign dy_now = trunc_q16(prod - {{5{amy[DIFF_W-1]}}, amy, 16'b0});
  always_comb begin
    man_dist = {1'b0, (dx[DLT_W-1] ? -dx : dx)}
             + {1'b0, (dy_now[DLT_W-1] ? -dy_now : dy_now)};
    close    = man_dist < (DLT_W+1)'(hit_distance);
  end

  assign rem_seg = SEG_W'(SEGMENTS) - seg;

  // Shared multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state)
      ST_WEIGHT: begin
        case (step)
          3'd0: begin mul_a = mul_op_t'(seg);     mul_b = mul_op_t'(seg);     end
          3'd1: begin mul_a = mul_op_t'(rem_seg); mul_b = mul_op_t'(rem_seg); end
          3'd2: begin mul_a = mul_op_t'(sqi);     mul_b = mul_op_t'(seg);     end
          3'd3: begin mul_a = mul_op_t'(sqr);     mul_b = mul_op_t'(rem_seg); end
          3'd4: begin mul_a = mul_op_t'(sqr);     mul_b = mul_op_t'(seg);     end
          3'd5: begin mul_a = mul_op_t'(sqi);     mul_b = mul_op_t'(rem_seg); end
          default: ;
        endcase
      end
      ST_SAMPLE: begin
        mul_a = mul_op_t'(w[step[1:0]]);
        mul_b = step[2] ? mul_op_t'(cy[step[1:0]]) : mul_op_t'(cx[step[1:0]]);
      end
      ST_DOT: begin
        case (step[1:0])
          2'd0: begin mul_a = mul_op_t'(abx); mul_b = mul_op_t'(amx); end
          2'd1: begin mul_a = mul_op_t'(aby); mul_b = mul_op_t'(amy); end
          2'd2: begin mul_a = mul_op_t'(abx); mul_b = mul_op_t'(abx); end
          default: begin mul_a = mul_op_t'(aby); mul_b = mul_op_t'(aby); end
        endcase
      end
      ST_DIST: begin
        mul_a = step[0] ? mul_op_t'(aby) : mul_op_t'(abx);
        mul_b = mul_op_t'(u);
      end
      default: ;
    endcase
  end

  bzl_mul u_mul (.a(mul_a), .b(mul_b), .p(prod));

  bzl_div u_div (
    .clk(clk), .rst(rst), .start(div_start),
    .num(num[DIV_W-1:0]), .den(acc[DIV_W-1:0]),
    .busy(div_busy), .done(div_done), .quot(div_quot)
  );

  // Sequencer state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      step  <= '0;
    end else begin
      state <= state_next;
      step  <= step_next;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    step_next  = 3'(step + 3'd1);
    div_start  = 1'b0;
    case (state)
      ST_IDLE: begin
        step_next = '0;
        if (req.valid) state_next = ST_SETUP;
      end
      ST_SETUP: begin
        step_next  = '0;
        state_next = ST_BOX;
      end
      ST_BOX: begin
        step_next  = '0;
        state_next = reject ? ST_DONE : ST_WEIGHT;
      end
      ST_WEIGHT: begin
        if (step == 3'd5) begin
          step_next  = '0;
          state_next = ST_SAMPLE;
        end
      end
      ST_SAMPLE: begin
        if (step == 3'd7) state_next = ST_ROUND;
      end
      ST_ROUND: begin
        step_next  = '0;
        state_next = ST_DIFF;
      end
      ST_DIFF: begin
        step_next  = '0;
        state_next = (px == lx && py == ly) ? ST_NEXT : ST_DOT;
      end
      ST_DOT: begin
        if (step == 3'd3) begin
          step_next  = '0;
          state_next = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        step_next = '0;
        if (num <= 0 || num >= acc) begin
          state_next = ST_DIST;
        end else begin
          div_start  = 1'b1;
          state_next = ST_DIVIDE;
        end
      end
      ST_DIVIDE: begin
        step_next = '0;
        if (div_done) state_next = ST_DIST;
      end
      ST_DIST: begin
        // y product is on the multiplier in the second step
        if (step == 3'd1) begin
          step_next  = '0;
          state_next = close ? ST_DONE : ST_NEXT;
        end
      end
      ST_NEXT: begin
        step_next  = '0;
        state_next = (seg == SEG_W'(SEGMENTS)) ? ST_DONE : ST_WEIGHT;
      end
      ST_DONE: begin
        step_next = '0;
        if (!rsp_valid || rsp.ready) state_next = ST_IDLE;
      end
      default: begin
        step_next  = '0;
        state_next = ST_IDLE;
      end
    endcase
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (req.valid) begin
          sx <= req.start_x; sy <= req.start_y;
          ex <= req.end_x;   ey <= req.end_y;
          qx <= req.query_x; qy <= req.query_y;
          hit_r <= 1'b0;
        end
      end
      ST_SETUP: begin
        cx[0] <= coord_t'(sx);
        cx[1] <= fold ? c1_pull : c1;
        cx[2] <= fold ? c2_pull : c2;
        cx[3] <= coord_t'(ex);
        cy[0] <= coord_t'(sy);
        cy[1] <= coord_t'(sy);
        cy[2] <= coord_t'(ey);
        cy[3] <= coord_t'(ey);
      end
      ST_BOX: begin
        seg <= SEG_W'(1);
        lx  <= cx[0];
        ly  <= cy[0];
      end
      ST_WEIGHT: begin
        case (step)
          3'd0: sqi  <= prod[12:0];
          3'd1: sqr  <= prod[12:0];
          3'd2: w[3] <= prod[WGT_W-1:0];
          3'd3: w[0] <= prod[WGT_W-1:0];
          3'd4: w[1] <= prod[WGT_W-1:0] + {prod[WGT_W-2:0], 1'b0};
          default: w[2] <= prod[WGT_W-1:0] + {prod[WGT_W-2:0], 1'b0};
        endcase
      end
      ST_SAMPLE: begin
        if (step[1:0] == 2'd0) acc <= acc_t'(prod);
        else                   acc <= acc + acc_t'(prod);
        if (step == 3'd4) px <= round_sample(acc);
      end
      ST_ROUND: py <= round_sample(acc);
      ST_DIFF: begin
        abx <= diff_t'(px) - diff_t'(lx);
        aby <= diff_t'(py) - diff_t'(ly);
        amx <= diff_t'(qx) - diff_t'(lx);
        amy <= diff_t'(qy) - diff_t'(ly);
      end
      ST_DOT: begin
        if (step[0] == 1'b0) acc <= acc_t'(prod);
        else                 acc <= acc + acc_t'(prod);
        if (step[1:0] == 2'd2) num <= acc;
      end
      ST_DECIDE: begin
        if (num <= 0)        u <= '0;
        else if (num >= acc) u <= U_W'(1) << Q_W;
      end
      ST_DIVIDE: begin
        if (div_done) u <= {1'b0, div_quot};
      end
      ST_DIST: begin
        if (step == 3'd0) dx <= trunc_q16(prod - {{5{amx[DIFF_W-1]}}, amx, 16'b0});
        if (step == 3'd1 && close) hit_r <= 1'b1;
      end
      ST_NEXT: begin
        lx  <= px;
        ly  <= py;
        seg <= SEG_W'(seg + SEG_W'(1));
      end
      default: ;
    endcase
  end

  // Response register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (state == ST_DONE && (!rsp_valid || rsp.ready)) begin
      rsp_valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp_valid <= 1'b0;
    end
  end
  always_ff @(posedge clk) begin
    if (state == ST_DONE && (!rsp_valid || rsp.ready)) rsp_hit <= hit_r;
  end

  assign req.ready = (state == ST_IDLE);
  assign rsp.valid = rsp_valid;
  assign rsp.hit   = rsp_hit;

  // Checks
  a_div_in_divide: assert property (@(posedge clk) disable iff (rst)
    div_busy |-> (state == ST_DIVIDE))
    else $error("divider busy outside divide state");

  a_seg_range: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SAMPLE) |-> (seg != '0 && seg <= SEG_W'(SEGMENTS)))
    else $error("segment index out of range");

  a_hit_needs_dist: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp_hit) |-> (hit_distance != 8'd0))
    else $error("hit reported with zero distance");

endmodule
